/* hdl/pidt_pkg.sv */
// Shared constants, codes and control types of the PID temperature regulator.
package pidt_pkg;

  localparam int DATA_W      = 32;
  localparam int INT_W       = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 48;
  localparam int MUL_CHUNK_W = MUL_B_W / 2;
  localparam int PP_W        = MUL_A_W + MUL_CHUNK_W;
  localparam int ACC_W       = MUL_A_W + MUL_B_W;
  localparam int DRV_W       = 65;
  localparam int DVD_W       = 49;
  localparam int QUO_W       = 33;
  localparam int DIV_STEPS   = QUO_W;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 2'd3;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [INT_W-1:0]  S48_MAX = 48'h7fff_ffff_ffff;
  localparam logic [INT_W-1:0]  S48_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    OP_INC = 2'd0,
    OP_KP  = 2'd1,
    OP_KI  = 2'd2,
    OP_KD  = 2'd3
  } mul_op_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic    load;
    logic    prep;
    logic    div_start;
    mul_op_t mul_op;
    logic    mul_ld;
    logic    mul_lo;
    logic    mul_hi;
    logic    mul_acc;
    logic    mul_use;
    logic    deriv;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

/* hdl/pidt_in_if.sv */
// Input channel carrying one measurement item.
interface pidt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidt_pkg::DATA_W-1:0]  measured_temp;
  logic signed [pidt_pkg::DATA_W-1:0]  wall_temp;
  logic        [pidt_pkg::DATA_W-1:0]  step_dt;
  logic                                new_step;

  modport source (output valid, measured_temp, wall_temp, step_dt, new_step, input ready);
  modport sink   (input valid, measured_temp, wall_temp, step_dt, new_step, output ready);
endinterface

/* hdl/pidt_out_if.sv */
// Result channel carrying the new wall temperature, the drive and the saturation flag.
interface pidt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidt_pkg::DATA_W-1:0]  new_wall_temp;
  logic signed [pidt_pkg::DATA_W-1:0]  drive;
  logic                                saturated;

  modport source (output valid, new_wall_temp, drive, saturated, input ready);
  modport sink   (input valid, new_wall_temp, drive, saturated, output ready);
endinterface

/* hdl/pidt_cfg_if.sv */
// Configuration write channel carrying a register index and write data.
interface pidt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pidt_pkg::CFG_IDX_W-1:0]     index;
  logic [pidt_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pid_trapezoid_temperature_regulator_top.sv */
// Top level of the PID temperature regulator with trapezoidal error integral.
//
// Each transfer on the input channel yields exactly one transfer on the result
// channel. The block takes no new item until it is through with the current
// one; a result held back on the output stalls the block only at the final
// step. The time per item is set by the 33-step restoring divider for the
// derivative, which runs alongside the shared 33x24 multiplier that forms the
// integral increment and the proportional and integral terms; the derivative
// term uses the multiplier once the quotient is ready. Values are Q16.16, signed
// but for the unsigned time step; the error integral is kept as Q32.16, and
// every clamp, as well as a zero time step, raises the saturated flag.
// Configuration registers are written through their own channel, which is always
// ready; a write takes effect for the next input transfer only if the user makes
// it while no item is in progress; the block itself does not enforce this.
module pid_trapezoid_temperature_regulator_top (
  input  logic        clk,
  input  logic        rst_n,
  pidt_in_if.sink     in_chan,
  pidt_out_if.source  out_chan,
  pidt_cfg_if.sink    cfg_chan
);

  pidt_pkg::cfg_wr_t  cfg_wr;
  pidt_pkg::cmd_t     cmd;
  pidt_pkg::sts_t     sts;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.en      = cfg_chan.valid;
  assign cfg_wr.index   = cfg_chan.index;
  assign cfg_wr.data    = cfg_chan.data;

  pidt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidt_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr            (cfg_wr),
    .cmd               (cmd),
    .sts               (sts),
    .in_measured_temp  (in_chan.measured_temp),
    .in_wall_temp      (in_chan.wall_temp),
    .in_step_dt        (in_chan.step_dt),
    .in_new_step       (in_chan.new_step),
    .out_new_wall_temp (out_chan.new_wall_temp),
    .out_drive         (out_chan.drive),
    .out_saturated     (out_chan.saturated)
  );

  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_chan.valid || out_chan.ready))
    else $error("Result register loaded while an earlier result was still pending.");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("Divider started while still busy.");

  a_kd_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_ld && cmd.mul_op == pidt_pkg::OP_KD) |-> !sts.div_busy)
    else $error("Derivative term loaded before the quotient was ready.");

  a_accept_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !cmd.fin)
    else $error("Result produced in the cycle right after an input transfer.");

endmodule

/* hdl/pidt_div.sv */
// Restoring divider that produces one quotient bit per cycle for the derivative.
module pidt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pidt_pkg::DVD_W-1:0]    dividend,
  input  logic [pidt_pkg::DATA_W-1:0]   divisor,
  output logic                          busy,
  output logic [pidt_pkg::QUO_W-1:0]    quotient,
  output logic                          ovf
);

  localparam int CNT_W = $clog2(pidt_pkg::DIV_STEPS + 1);
  localparam int HI_W  = pidt_pkg::DVD_W - pidt_pkg::QUO_W;

  logic                          busy_r, busy_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [pidt_pkg::DATA_W-1:0]   rem_r, rem_nxt;
  logic [pidt_pkg::QUO_W-1:0]    quo_r, quo_nxt;
  logic [pidt_pkg::DATA_W-1:0]   dvs_r, dvs_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [pidt_pkg::DATA_W:0]     shifted;
  logic                          ge;

  assign shifted = {rem_r, quo_r[pidt_pkg::QUO_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(pidt_pkg::DIV_STEPS);
      dvs_nxt  = divisor;
      ovf_nxt  = {{(pidt_pkg::DATA_W-HI_W){1'b0}}, dividend[pidt_pkg::DVD_W-1 -: HI_W]}
                 >= divisor;
      rem_nxt  = {{(pidt_pkg::DATA_W-HI_W){1'b0}}, dividend[pidt_pkg::DVD_W-1 -: HI_W]};
      quo_nxt  = dividend[pidt_pkg::QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = ge ? pidt_pkg::DATA_W'(shifted - {1'b0, dvs_r})
                    : shifted[pidt_pkg::DATA_W-1:0];
      quo_nxt  = {quo_r[pidt_pkg::QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign ovf      = ovf_r;

endmodule

/* hdl/pidt_datapath.sv */
// Datapath: configuration registers, controller state, shared multiplier and divider.
module pidt_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pidt_pkg::cfg_wr_t                   cfg_wr,
  input  pidt_pkg::cmd_t                      cmd,
  output pidt_pkg::sts_t                      sts,
  input  logic signed [pidt_pkg::DATA_W-1:0]  in_measured_temp,
  input  logic signed [pidt_pkg::DATA_W-1:0]  in_wall_temp,
  input  logic        [pidt_pkg::DATA_W-1:0]  in_step_dt,
  input  logic                                in_new_step,
  output logic signed [pidt_pkg::DATA_W-1:0]  out_new_wall_temp,
  output logic signed [pidt_pkg::DATA_W-1:0]  out_drive,
  output logic                                out_saturated
);

  localparam int DW  = pidt_pkg::DATA_W;
  localparam int IW  = pidt_pkg::INT_W;
  localparam int AW  = pidt_pkg::MUL_A_W;
  localparam int BW  = pidt_pkg::MUL_B_W;
  localparam int CW  = pidt_pkg::MUL_CHUNK_W;
  localparam int PW  = pidt_pkg::PP_W;
  localparam int XW  = pidt_pkg::ACC_W;
  localparam int RW  = pidt_pkg::DRV_W;
  localparam int TW  = RW - 2;

  function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  function automatic logic [IW-1:0] abs48(input logic [IW-1:0] v);
    return v[IW-1] ? IW'(-v) : v;
  endfunction

  logic [DW-1:0]  target_r, kp_r, ki_r, kd_r;
  logic [DW-1:0]  cur_err_r, cur_err_nxt;
  logic [DW-1:0]  prev_err_r, prev_err_nxt;
  logic [IW-1:0]  integral_r, integral_nxt;
  logic           flag_r, flag_nxt;

  logic [DW-1:0]  wall_r, dt_r;
  logic [AW-1:0]  sum_mag_r, diff_mag_r;
  logic           sum_neg_r, diff_neg_r;
  logic [AW-1:0]  mul_a_r, mul_a_nxt;
  logic [BW-1:0]  mul_b_r, mul_b_nxt;
  logic           mul_neg_r, mul_neg_nxt;
  logic [PW-1:0]  pp_r;
  logic [XW-1:0]  acc_r, acc_nxt;
  logic [RW-1:0]  drive_acc_r, drive_acc_nxt;
  logic [DW-1:0]  deriv_r, deriv_nxt;
  logic [DW-1:0]  out_wall_r, out_drive_r;
  logic           out_sat_r;

  logic [DW:0]    err_wide;
  logic           err_ovf;
  logic [DW-1:0]  err_sat;
  logic [AW-1:0]  sum_wide, diff_wide;
  logic [CW-1:0]  mul_chunk;
  logic [PW-1:0]  pp_prod;
  logic [XW-1:0]  rnd;
  logic [IW-1:0]  inc_mag;
  logic [IW+1:0]  inc_wide, int_wide;
  logic           int_ovf;
  logic [TW-1:0]  term_mag;
  logic [RW-1:0]  term_wide;
  logic [pidt_pkg::DVD_W-1:0] dividend;
  logic [pidt_pkg::QUO_W-1:0] div_quo;
  logic           div_ovf, div_busy;
  logic           big_pos, big_neg;
  logic           drv_ovf, res_ovf;
  logic [DW-1:0]  drive32, result32;
  logic [DW:0]    res_wide;

  pidt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (div_quo),
    .ovf      (div_ovf)
  );

  assign sts.div_busy = div_busy;

  assign dividend = {diff_mag_r, 16'd0} + pidt_pkg::DVD_W'(dt_r[DW-1:1]);

  assign err_wide = {target_r[DW-1], target_r} - {in_measured_temp[DW-1], in_measured_temp};
  assign err_ovf  = err_wide[DW] != err_wide[DW-1];
  assign err_sat  = err_ovf ? (err_wide[DW] ? pidt_pkg::S32_MIN : pidt_pkg::S32_MAX)
                            : err_wide[DW-1:0];

  assign sum_wide  = {cur_err_r[DW-1], cur_err_r} + {prev_err_r[DW-1], prev_err_r};
  assign diff_wide = {cur_err_r[DW-1], cur_err_r} - {prev_err_r[DW-1], prev_err_r};

  assign mul_chunk = cmd.mul_hi ? mul_b_r[BW-1:CW] : mul_b_r[CW-1:0];
  assign pp_prod   = PW'(mul_a_r) * PW'(mul_chunk);
  assign rnd       = (cmd.mul_op == pidt_pkg::OP_INC) ? XW'(1) << 16 : XW'(1) << 15;

  assign inc_mag  = acc_r[IW+16:17];
  assign inc_wide = sum_neg_r ? (IW+2)'(-{2'b00, inc_mag}) : {2'b00, inc_mag};
  assign int_wide = {{2{integral_r[IW-1]}}, integral_r} + inc_wide;
  assign int_ovf  = !((&int_wide[IW+1:IW-1]) || !(|int_wide[IW+1:IW-1]));

  assign term_mag  = acc_r[TW+15:16];
  assign term_wide = {2'b00, term_mag};

  assign big_pos = div_ovf || div_quo[DW] || div_quo[DW-1];
  assign big_neg = div_ovf || div_quo[DW] || (div_quo[DW-1] && (|div_quo[DW-2:0]));

  assign drv_ovf  = !((&drive_acc_r[RW-1:DW-1]) || !(|drive_acc_r[RW-1:DW-1]));
  assign drive32  = drv_ovf ? (drive_acc_r[RW-1] ? pidt_pkg::S32_MIN : pidt_pkg::S32_MAX)
                            : drive_acc_r[DW-1:0];
  assign res_wide = {wall_r[DW-1], wall_r} + {drive32[DW-1], drive32};
  assign res_ovf  = res_wide[DW] != res_wide[DW-1];
  assign result32 = res_ovf ? (res_wide[DW] ? pidt_pkg::S32_MIN : pidt_pkg::S32_MAX)
                            : res_wide[DW-1:0];

  always_comb begin
    cur_err_nxt   = cur_err_r;
    prev_err_nxt  = prev_err_r;
    integral_nxt  = integral_r;
    flag_nxt      = flag_r;
    drive_acc_nxt = drive_acc_r;
    deriv_nxt     = deriv_r;
    acc_nxt       = acc_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_neg_nxt   = mul_neg_r;

    if (cmd.load) begin
      prev_err_nxt  = in_new_step ? cur_err_r : prev_err_r;
      cur_err_nxt   = err_sat;
      flag_nxt      = err_ovf;
      drive_acc_nxt = '0;
    end

    if (cmd.mul_ld) begin
      case (cmd.mul_op)
        pidt_pkg::OP_INC: begin
          mul_a_nxt   = sum_mag_r;
          mul_b_nxt   = BW'(dt_r);
          mul_neg_nxt = sum_neg_r;
        end
        pidt_pkg::OP_KP: begin
          mul_a_nxt   = AW'(abs32(kp_r));
          mul_b_nxt   = BW'(abs32(cur_err_r));
          mul_neg_nxt = kp_r[DW-1] ^ cur_err_r[DW-1];
        end
        pidt_pkg::OP_KI: begin
          mul_a_nxt   = AW'(abs32(ki_r));
          mul_b_nxt   = abs48(integral_r);
          mul_neg_nxt = ki_r[DW-1] ^ integral_r[IW-1];
        end
        default: begin
          mul_a_nxt   = AW'(abs32(kd_r));
          mul_b_nxt   = BW'(abs32(deriv_r));
          mul_neg_nxt = kd_r[DW-1] ^ deriv_r[DW-1];
        end
      endcase
    end

    if (cmd.mul_hi) begin
      acc_nxt = XW'(pp_r) + rnd;
    end else if (cmd.mul_acc) begin
      acc_nxt = acc_r + (XW'(pp_r) << CW);
    end

    if (cmd.mul_use) begin
      if (cmd.mul_op == pidt_pkg::OP_INC) begin
        if (int_ovf) begin
          integral_nxt = int_wide[IW+1] ? pidt_pkg::S48_MIN : pidt_pkg::S48_MAX;
          flag_nxt     = 1'b1;
        end else begin
          integral_nxt = int_wide[IW-1:0];
        end
      end else begin
        drive_acc_nxt = mul_neg_r ? drive_acc_r - term_wide : drive_acc_r + term_wide;
      end
    end

    if (cmd.deriv) begin
      if (dt_r == '0) begin
        deriv_nxt = '0;
        flag_nxt  = 1'b1;
      end else if (diff_neg_r) begin
        if (big_neg) begin
          deriv_nxt = pidt_pkg::S32_MIN;
          flag_nxt  = 1'b1;
        end else begin
          deriv_nxt = DW'(-div_quo[DW-1:0]);
        end
      end else if (big_pos) begin
        deriv_nxt = pidt_pkg::S32_MAX;
        flag_nxt  = 1'b1;
      end else begin
        deriv_nxt = div_quo[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      cur_err_r  <= '0;
      prev_err_r <= '0;
      integral_r <= '0;
    end else begin
      if (cfg_wr.en) begin
        case (cfg_wr.index)
          pidt_pkg::REG_TARGET: target_r <= cfg_wr.data;
          pidt_pkg::REG_KP:     kp_r     <= cfg_wr.data;
          pidt_pkg::REG_KI:     ki_r     <= cfg_wr.data;
          pidt_pkg::REG_KD:     kd_r     <= cfg_wr.data;
          default: ;
        endcase
      end
      cur_err_r  <= cur_err_nxt;
      prev_err_r <= prev_err_nxt;
      integral_r <= integral_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flag_r      <= flag_nxt;
    drive_acc_r <= drive_acc_nxt;
    deriv_r     <= deriv_nxt;
    acc_r       <= acc_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    mul_neg_r   <= mul_neg_nxt;
    if (cmd.load) begin
      wall_r <= in_wall_temp;
      dt_r   <= in_step_dt;
    end
    if (cmd.prep) begin
      sum_neg_r  <= sum_wide[AW-1];
      sum_mag_r  <= sum_wide[AW-1] ? AW'(-sum_wide) : sum_wide;
      diff_neg_r <= diff_wide[AW-1];
      diff_mag_r <= diff_wide[AW-1] ? AW'(-diff_wide) : diff_wide;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp_r <= pp_prod;
    end
    if (cmd.fin) begin
      out_wall_r  <= result32;
      out_drive_r <= drive32;
      out_sat_r   <= flag_r || drv_ovf || res_ovf;
    end
  end

  assign out_new_wall_temp = out_wall_r;
  assign out_drive         = out_drive_r;
  assign out_saturated     = out_sat_r;

endmodule

/* hdl/pidt_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
module pidt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pidt_pkg::sts_t   sts,
  output pidt_pkg::cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_PREP  = 10'b00_0000_0010,
    S_MLD   = 10'b00_0000_0100,
    S_MLO   = 10'b00_0000_1000,
    S_MHI   = 10'b00_0001_0000,
    S_MACC  = 10'b00_0010_0000,
    S_MUSE  = 10'b00_0100_0000,
    S_DWAIT = 10'b00_1000_0000,
    S_DERIV = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  pidt_pkg::mul_op_t  op_r, op_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_op    = op_r;
    in_ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        op_nxt    = pidt_pkg::OP_INC;
        state_nxt = S_MLD;
      end
      S_MLD: begin
        cmd.mul_ld    = 1'b1;
        cmd.div_start = op_r == pidt_pkg::OP_INC;
        state_nxt     = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MACC;
      end
      S_MACC: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = S_MUSE;
      end
      S_MUSE: begin
        cmd.mul_use = 1'b1;
        case (op_r)
          pidt_pkg::OP_INC: begin
            op_nxt    = pidt_pkg::OP_KP;
            state_nxt = S_MLD;
          end
          pidt_pkg::OP_KP: begin
            op_nxt    = pidt_pkg::OP_KI;
            state_nxt = S_MLD;
          end
          pidt_pkg::OP_KI: begin
            state_nxt = S_DWAIT;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_DERIV;
        end
      end
      S_DERIV: begin
        cmd.deriv = 1'b1;
        op_nxt    = pidt_pkg::OP_KD;
        state_nxt = S_MLD;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= pidt_pkg::OP_INC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* tb/sv/tb_pid_trapezoid_temperature_regulator_top.sv */
// Self-checking testbench of the PID temperature regulator with trapezoidal error integral.
module tb_pid_trapezoid_temperature_regulator_top;
  import pidt_pkg::*;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S48_HI = 64'sd140737488355327;
  localparam longint S48_LO = -64'sd140737488355328;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 8;

  typedef struct packed {
    logic [DATA_W-1:0] new_wall_temp;
    logic [DATA_W-1:0] drive;
    logic              saturated;
  } wall_update_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {STYLE_TYPICAL, STYLE_WIDE, STYLE_EXTREME} gain_style_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [DATA_W-1:0] f0;
    logic [DATA_W-1:0] f1;
    logic [DATA_W-1:0] f2;
    logic [DATA_W-1:0] f3;
    logic              typed;
    logic [DATA_W-1:0] x_wall;
    logic [DATA_W-1:0] x_drive;
    logic              x_sat;
  } plan_row_t;

  logic clk;
  logic rst_n;

  pidt_in_if  in_chan();
  pidt_out_if out_chan();
  pidt_cfg_if cfg_chan();

  pid_trapezoid_temperature_regulator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  longint set_target, gain_p, gain_i, gain_d;
  longint err_now, err_last, err_sum48;

  wall_update_t pending_results[$];
  wall_update_t oldest_result;
  wall_update_t no_result = '0;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;

  plan_row_t directed_plan [28] = '{
    '{ROW_ITEM, 32'h0, 32'h1234_5678, 32'h0001_0000, 32'd1, 1'b1, 32'h1234_5678, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h0, S32_MIN, 32'h0, 32'd0, 1'b1, S32_MIN, 32'h0, 1'b1},
    '{ROW_ITEM, S32_MIN, S32_MAX, 32'h0001_0000, 32'd1, 1'b1, S32_MAX, 32'h0, 1'b1},
    '{ROW_ITEM, S32_MAX, 32'h0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h00A0_0000, 32'h00C8_0000, 32'h8000, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG, S32_MAX, S32_MAX, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, S32_MIN, S32_MIN, 32'h0001_0000, 32'd1, 1'b1, 32'hFFFF_FFFF, S32_MAX, 1'b1},
    '{ROW_ITEM, S32_MAX, S32_MAX, 32'h8000, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h7FFF_0000, 32'h0, 32'h0001_0000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, S32_MAX, 32'h0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, S32_MAX, S32_MAX, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, S32_MIN, S32_MIN, 32'h1, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h0, 32'h0, 32'h0, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, S32_MIN, 32'h1234_5678, 32'h8000_0000, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG, 32'h012C_0000, 32'h0001_0000, 32'h8000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012B_0000, 32'h0120_0000, 32'h0001_0000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012B_8000, 32'h0121_0000, 32'h0001_8000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012C_0000, 32'h0122_0000, 32'h0001_8000, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012C_8000, 32'h0123_0000, 32'h4000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012D_0001, 32'h0124_0000, 32'h0003_0000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012B_FFFF, 32'h7FFF_0000, 32'h0001_0000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h012C_0000, S32_MIN, 32'h3, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG, 32'hFFFF_FFFF, S32_MAX, 32'h1, S32_MIN, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h0, 32'h0, 32'h2, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFE, 32'h0, 32'h1, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_ITEM, 32'h4000_0000, 32'hC000_0000, 32'hFFFF_0000, 32'd1, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    logic [127:0]    prod;
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + 128'h8000) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic wall_update_t compute_regulation(input longint meas, input longint wall,
                                                      input longint unsigned dt, input bit ns);
    wall_update_t    r;
    bit              hit;
    longint          total, diff, inc, deriv, drv, nw;
    longint unsigned mag_sum, mag_diff, m, q;
    hit = 1'b0;
    if (ns) err_last = err_now;
    err_now = clamp(set_target - meas, S32_LO, S32_HI, hit);
    total = err_now + err_last;
    mag_sum = (total < 0) ? -total : total;
    m = mag_sum * dt;
    inc = longint'((m + 64'h1_0000) >> 17);
    if (total < 0) inc = -inc;
    err_sum48 = clamp(err_sum48 + inc, S48_LO, S48_HI, hit);
    diff = err_now - err_last;
    if (dt == 0) begin
      deriv = 0;
      hit = 1'b1;
    end else begin
      mag_diff = (diff < 0) ? -diff : diff;
      q = ((mag_diff << 16) + (dt >> 1)) / dt;
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      deriv = longint'(q);
      if (diff < 0) deriv = -deriv;
      deriv = clamp(deriv, S32_LO, S32_HI, hit);
    end
    drv = round_mul(gain_p, err_now) + round_mul(gain_i, err_sum48) + round_mul(gain_d, deriv);
    drv = clamp(drv, S32_LO, S32_HI, hit);
    nw = clamp(wall + drv, S32_LO, S32_HI, hit);
    r.new_wall_temp = nw[31:0];
    r.drive = drv[31:0];
    r.saturated = hit;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    reg_writes++;
  endtask

  task automatic apply_config(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] p,
                              input logic [DATA_W-1:0] i, input logic [DATA_W-1:0] d);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(REG_TARGET, t);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    cfg_chan.valid <= 1'b0;
    set_target = $signed(t);
    gain_p = $signed(p);
    gain_i = $signed(i);
    gain_d = $signed(d);
  endtask

  task automatic random_config(input gain_style_t style);
    logic [DATA_W-1:0] t, p, i, d;
    case (style)
      STYLE_TYPICAL: begin
        t = 32'h0100_0000 + $urandom_range(32'h00FF_FFFF);
        p = $urandom_range(32'h80000) - 32'h40000;
        i = $urandom_range(32'h20000) - 32'h10000;
        d = $urandom_range(32'h8000) - 32'h4000;
      end
      STYLE_WIDE: begin
        t = $urandom();
        p = $urandom();
        i = $urandom();
        d = $urandom();
      end
      default: begin
        t = pick_extreme();
        p = pick_extreme();
        i = pick_extreme();
        d = pick_extreme();
      end
    endcase
    apply_config(t, p, i, d);
  endtask

  task automatic push_item(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] w,
                           input logic [DATA_W-1:0] dt, input logic ns, input bit typed,
                           input wall_update_t fixed);
    wall_update_t want;
    int           gap;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      gap = $urandom_range(60, 1);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.measured_temp <= m;
    in_chan.wall_temp     <= w;
    in_chan.step_dt       <= dt;
    in_chan.new_step      <= ns;
    do @(posedge clk); while (!in_chan.ready);
    want = compute_regulation($signed(m), $signed(w), dt, ns);
    if (typed) want = fixed;
    pending_results.push_back(want);
    items_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL pid_trapezoid_temperature_regulator_top");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served    <= hold_asks;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", out_chan.new_wall_temp, 32'h0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_chan.new_wall_temp !== oldest_result.new_wall_temp)
          note_mismatch("new_wall_temp", out_chan.new_wall_temp, oldest_result.new_wall_temp);
        if (out_chan.drive !== oldest_result.drive)
          note_mismatch("drive", out_chan.drive, oldest_result.drive);
        if (out_chan.saturated !== oldest_result.saturated)
          note_mismatch("saturated", {31'd0, out_chan.saturated},
                        {31'd0, oldest_result.saturated});
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] m, w, dt, tgt;
    logic              ns;
    int unsigned       sel;
    wall_update_t      fixed;
    gain_style_t       style;

    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.measured_temp = '0;
    in_chan.wall_temp = '0;
    in_chan.step_dt = '0;
    in_chan.new_step = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    out_chan.ready = 1'b0;
    set_target = 0;
    gain_p = 0;
    gain_i = 0;
    gain_d = 0;
    err_now = 0;
    err_last = 0;
    err_sum48 = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_CFG) begin
        apply_config(directed_plan[k].f0, directed_plan[k].f1, directed_plan[k].f2,
                     directed_plan[k].f3);
      end else begin
        fixed = {directed_plan[k].x_wall, directed_plan[k].x_drive, directed_plan[k].x_sat};
        push_item(directed_plan[k].f0, directed_plan[k].f1, directed_plan[k].f2,
                  directed_plan[k].f3[0], directed_plan[k].typed, fixed);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4 || ph == 7) style = STYLE_TYPICAL;
      else if (ph < 6) style = STYLE_WIDE;
      else style = STYLE_EXTREME;
      random_config(style);
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 45; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 45; end
        default: begin send_pct = 22; recv_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) hold_asks++;
        tgt = set_target[31:0];
        sel = $urandom_range(99);
        if (sel < 70) begin
          m  = tgt + $urandom_range(32'h20_0000) - 32'h10_0000;
          w  = tgt + $urandom_range(32'h100_0000) - 32'h80_0000;
          dt = $urandom_range(32'h4_0000, 32'h1000);
          ns = ($urandom_range(3) != 0);
        end else if (sel < 85) begin
          m  = $urandom();
          w  = $urandom();
          dt = $urandom();
          ns = $urandom_range(1);
        end else if (sel < 95) begin
          m = tgt + $urandom_range(32'h2_0000) - 32'h1_0000;
          w = tgt;
          case ($urandom_range(4))
            0: dt = 32'h0;
            1: dt = 32'h1;
            2: dt = 32'hFFFF_FFFF;
            3: dt = 32'h8000_0000;
            default: dt = $urandom_range(16);
          endcase
          ns = $urandom_range(1);
        end else begin
          m  = pick_extreme();
          w  = pick_extreme();
          dt = $urandom();
          ns = 1'b1;
        end
        push_item(m, w, dt, ns, 1'b0, no_result);
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) note_mismatch("results never delivered", 32'h0, 32'h0);

    $display("Checked %0d results of %0d items after %0d register writes.",
             results_seen, items_sent, reg_writes);
    $display("Gains ran typical, wide and extreme, with sender gaps, receiver stalls and a hold.");
    if (mismatches == 0) begin
      $display("PASS pid_trapezoid_temperature_regulator_top");
    end else begin
      $display("FAIL pid_trapezoid_temperature_regulator_top");
    end
    $finish;
  end

endmodule
